// File: design/phr_pkg.sv
// ----------------------------------------------------------------------------
// phr_pkg
// Shared constants, operation codes and the cell-to-cell struct for the
// position history ring.
// ----------------------------------------------------------------------------
package phr_pkg;
  localparam int Depth = 32;
  localparam int IdxW = 8;
  localparam int PosW = 31;
  localparam int CntW = 9;
  localparam int PtrW = $clog2(Depth);

  localparam logic [3:0] FN_RECORD = 4'd0;
  localparam logic [3:0] FN_PREV   = 4'd1;
  localparam logic [3:0] FN_NEXT   = 4'd2;
  localparam logic [3:0] FN_CUR    = 4'd3;
  localparam logic [3:0] FN_FIND   = 4'd4;
  localparam logic [3:0] FN_GET    = 4'd5;
  localparam logic [3:0] FN_COUNT  = 4'd6;
  localparam logic [3:0] FN_CLRALL = 4'd7;
  localparam logic [3:0] FN_CLRRNG = 4'd8;

  // slot contents as seen by neighbours
  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] value;
  } slot_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic            rotate;  // shift the ring by one place
    logic            clr_all;
    logic            clr_rng; // clear the cell at the head if in range
    logic            wr_head;
    logic [PosW-1:0] lo;
    logic [PosW-1:0] hi;
    logic [PosW-1:0] wdata;
  } cell_ctl_t;
endpackage

// File: design/phr_cell.sv
// ----------------------------------------------------------------------------
// phr_cell
// One slot of the ring; on rotate takes its neighbour's slot, which the head may clear.
// ----------------------------------------------------------------------------
module phr_cell (
  input  logic              clk,
  input  logic              rst,
  input  phr_pkg::cell_ctl_t ctl,
  input  logic              is_head,
  input  phr_pkg::slot_t    from_nb,
  output phr_pkg::slot_t    slot
);
  import phr_pkg::*;

  // range test on the slot arriving at the head
  logic in_rng;
  assign in_rng = from_nb.valid && from_nb.value >= ctl.lo && from_nb.value <= ctl.hi;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      slot.valid <= 1'b0;
      slot.value <= '0;
    end else if (ctl.rotate) begin
      if (is_head && ctl.clr_rng && in_rng) slot <= '0;
      else slot <= from_nb;
    end else if (is_head && ctl.wr_head) begin
      slot.valid <= 1'b1;
      slot.value <= ctl.wdata;
    end
  end
endmodule

// File: design/position_history_ring_top.sv
// ----------------------------------------------------------------------------
// position_history_ring_top
// Circular history of positions built as a rotating chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready carries func, position, range_end and
//    slot_index; each transaction gives exactly one result transaction on
//    out_valid/out_ready (result_value, found, found_index, mark_count).
//  - The slots form a ring of cells that rotates by one place per cycle
//    while an operation aligns or walks. A rotation offset tracks which
//    cell sits at the head (cell 0); only the head is read or written,
//    but for clear all. Clear range empties slots as they arrive at the head.
//  - Every accepted operation with a valid code and slot index first
//    rotates the wanted slot to the head, then (for walking ops) sweeps
//    the whole ring once. The steps are accept, align, walk and register
//    the result; the single-step rotation sets how long align and walk take.
//  - One transaction is in flight at a time; in_ready is high only while
//    idle, which is the cycle after the result is taken, so no new
//    transaction is accepted before the last result is taken. The result
//    sits in an output register until taken; a stalled receiver holds the block.
//  - Reset empties all slots, sets current to 0 and insert to Depth-1.
// ----------------------------------------------------------------------------
module position_history_ring_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            func,
  input  logic [30:0]           position,
  input  logic [30:0]           range_end,
  input  logic [7:0]            slot_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    result_value,
  output logic                  found,
  output logic [7:0]            found_index,
  output logic [phr_pkg::CntW-1:0] mark_count
);
  import phr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;

  slot_t     slots [Depth];
  cell_ctl_t ctl;
  logic [1:0] state;
  logic [PtrW-1:0] head;     // logical index sitting in cell 0
  logic [PtrW-1:0] target;
  logic [PtrW-1:0] cur_ptr, ins_ptr;
  logic [PtrW:0]   steps;
  logic [3:0]      op;
  logic [PosW-1:0] pos_q, end_q;
  logic            dir_fwd;
  logic [31:0]     oldw;
  logic            hit;
  logic [PtrW-1:0] hit_idx;
  logic [31:0]     hit_w;
  logic            nb_valid;  // first slot stepped to during a browse
  logic [PtrW-1:0] nb_idx;

  genvar g;
  generate
    for (g = 0; g < Depth; g++) begin : g_cell
      // forward rotation: cell g takes cell g+1, so head index advances
      phr_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .is_head(g == 0),
        .from_nb(dir_fwd ? slots[(g+1)%Depth] : slots[(g+Depth-1)%Depth]),
        .slot(slots[g])
      );
    end
  endgenerate

  logic [31:0] head_w;
  assign head_w = slots[0].valid ? {1'b0, slots[0].value} : 32'hFFFF_FFFF;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] a);
    inc = (a == PtrW'(Depth-1)) ? '0 : a + 1'b1;
  endfunction
  function automatic logic [PtrW-1:0] dec(input logic [PtrW-1:0] a);
    dec = (a == '0) ? PtrW'(Depth-1) : a - 1'b1;
  endfunction

  logic walk_op;
  assign walk_op = (op == FN_PREV) || (op == FN_NEXT) || (op == FN_FIND) ||
                   (op == FN_COUNT) || (op == FN_CLRRNG);

  always_comb begin
    ctl = '0;
    ctl.lo = pos_q;
    ctl.hi = end_q;
    ctl.wdata = pos_q;
    if (state == ST_ALIGN && head != target) ctl.rotate = 1'b1;
    if (state == ST_ALIGN && head == target) begin
      ctl.wr_head = (op == FN_RECORD);
      ctl.clr_all = (op == FN_CLRALL);
    end
    if (state == ST_WALK) begin
      ctl.clr_rng = (op == FN_CLRRNG);
      ctl.rotate = 1'b1;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      cur_ptr <= '0;
      ins_ptr <= PtrW'(Depth-1);
      out_valid <= 1'b0;
      dir_fwd <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: if (in_valid) begin
          op <= func;
          pos_q <= position;
          end_q <= range_end;
          steps <= '0;
          hit <= 1'b0;
          hit_idx <= '0;
          hit_w <= 32'hFFFF_FFFF;
          result_value <= '1;
          found <= 1'b0;
          found_index <= '0;
          mark_count <= '0;
          case (func)
            FN_RECORD: begin
              target <= inc(ins_ptr);
              dir_fwd <= 1'b1;
            end
            FN_PREV: begin
              target <= cur_ptr;
              dir_fwd <= 1'b0;
            end
            FN_NEXT, FN_CUR: begin
              target <= cur_ptr;
              dir_fwd <= 1'b1;
            end
            FN_GET: begin
              target <= slot_index[PtrW-1:0];
              dir_fwd <= 1'b1;
            end
            default: begin
              target <= '0;
              dir_fwd <= 1'b1;
            end
          endcase
          state <= (func == FN_GET && slot_index >= IdxW'(Depth)) ? ST_OUT :
                   (func > FN_CLRRNG) ? ST_OUT : ST_ALIGN;
        end
        ST_ALIGN: begin
          if (head != target) begin
            head <= dir_fwd ? inc(head) : dec(head);
          end else begin
            oldw <= head_w;
            if (op == FN_RECORD) begin
              ins_ptr <= target;
              cur_ptr <= target;
            end
            if (op == FN_CLRALL) begin
              cur_ptr <= '0;
              ins_ptr <= PtrW'(Depth-1);
            end
            if (op == FN_CUR || op == FN_GET) result_value <= head_w;
            state <= walk_op ? ST_WALK : ST_OUT;
          end
        end
        ST_WALK: begin
          head <= dir_fwd ? inc(head) : dec(head);
          steps <= steps + 1'b1;
          // the last step revisits the first slot, so it is not counted
          if (op == FN_COUNT && slots[0].valid && steps != (PtrW+1)'(Depth))
            mark_count <= mark_count + 1'b1;
          if (op == FN_FIND && !found && slots[0].valid && slots[0].value == pos_q) begin
            found <= 1'b1;
            found_index <= IdxW'(head);
          end
          // with no differing slot, a browse still lands on its first
          // neighbour when that neighbour holds a copy of the old value
          if (steps == (PtrW+1)'(1)) begin
            nb_valid <= slots[0].valid;
            nb_idx <= head;
          end
          // browse: first non-empty slot differing from the old word
          if ((op == FN_PREV || op == FN_NEXT) && steps != '0 && !hit &&
              slots[0].valid && head_w != oldw) begin
            hit <= 1'b1;
            hit_idx <= head;
            hit_w <= head_w;
          end
          if (steps == (PtrW+1)'(Depth)) state <= ST_OUT;
        end
        default: begin
          if (!out_valid) begin
            if (op == FN_PREV || op == FN_NEXT) begin
              if (hit) begin
                result_value <= hit_w;
                cur_ptr <= hit_idx;
              end else begin
                result_value <= oldw;
                if (nb_valid) cur_ptr <= nb_idx;
              end
            end
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// File: design/phr_checker.sv
// ----------------------------------------------------------------------------
// phr_checker
// Port-level checks for the position history ring.
// ----------------------------------------------------------------------------
module phr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_value,
  input logic        found,
  input logic [8:0]  mark_count
);
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("result dropped");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mark_count <= 9'd32) else $error("count too large");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_found_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> mark_count == 9'd0) else $error("find gave a count");
endmodule

bind position_history_ring_top phr_checker u_phr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
  .found(found), .mark_count(mark_count)
);
